### src/sepwm_pkg.sv
// Package for the single-edge PWM timer: sizes, register indexes and beat types.
// Used by sepwm_skid and single_edge_pwm_timer; depends on nothing.
`default_nettype none

package sepwm_pkg;

    // channel count and main counter width
    localparam int CHANNELS    = 4;
    localparam int COUNT_WIDTH = 32;

    // field widths fixed by the interface
    localparam int CH_IDX_W  = 2;
    localparam int DUR_W     = 32;
    localparam int LEVELS_W  = 4;
    localparam int CNT_OUT_W = 32;
    localparam int MATCH_W   = 33;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // storage index into the match array
    localparam int MATCH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALE_VALUE     = 3'd0,
        CFG_PERIOD_COUNT       = 3'd1,
        CFG_PERIOD_SLOT        = 3'd2,
        CFG_COUNTER_ENABLE     = 3'd3,
        CFG_OUTPUT_ENABLE_MASK = 3'd4
    } cfg_idx_t;

    // item kinds
    typedef enum logic {
        KIND_TICK         = 1'b0,
        KIND_SET_DURATION = 1'b1
    } kind_t;

    // input beat
    typedef struct packed {
        logic                kind;
        logic [CH_IDX_W-1:0] channel;
        logic [DUR_W-1:0]    duration;
    } sepwm_in_t;

    // result beat
    typedef struct packed {
        logic [LEVELS_W-1:0]  levels;
        logic [CNT_OUT_W-1:0] count;
        logic                 cycle_start;
    } sepwm_out_t;

endpackage

`default_nettype wire

### src/single_edge_pwm_timer.sv
// Top level of the four-channel single-edge PWM timer.
// Depends on sepwm_pkg and sepwm_skid.
`default_nettype none

// Prescaled match timer with single-edge PWM outputs. Each accepted beat is
// either a tick, which, while the counter is enabled, steps the prescale
// counter and, when it reaches prescale_value, the main counter (wrapping
// after period_count-1), or a duration write, which stores period_count minus
// the clamped duration as a channel's match (a zero duration keeps the channel
// low). Enabled channels other than period_slot are high while the counter is
// at or above their match. One beat is taken per clock while the result path
// is not stalled; the result of a beat passes the result register behind the
// state update and the output register of the two-entry result buffer before
// it is offered on the m_ channel. Configuration writes are applied at once
// and writing period_count or period_slot clears both counters.
module single_edge_pwm_timer
    import sepwm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sepwm_in_t             s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sepwm_out_t                 m_data
);

    // configuration registers
    logic [31:0]         prescale_value_reg;
    logic [31:0]         period_count_reg;
    logic [CH_IDX_W-1:0] period_slot_reg;
    logic                counter_enable_reg;
    logic [LEVELS_W-1:0] output_enable_mask_reg;

    // timer state
    logic [31:0]            prescale_count_reg, prescale_count_next;
    logic [COUNT_WIDTH-1:0] timer_count_reg, timer_count_next;
    logic [MATCH_W-1:0]     match_reg [CHANNELS];
    logic [MATCH_W-1:0]     match_value_next;
    logic                   match_write;
    logic [MATCH_IDX_W-1:0] match_idx;

    logic       accept;
    logic       wrapped;
    sepwm_out_t result;
    logic       res_valid_reg;
    sepwm_out_t res_reg;
    logic       res_ready;

    assign accept = s_valid && s_ready;

    // tick path: prescaler then main counter with wrap at period
    always_comb begin
        logic [MATCH_W-1:0] step;
        step                = MATCH_W'(timer_count_reg) + MATCH_W'(1);
        prescale_count_next = prescale_count_reg;
        timer_count_next    = timer_count_reg;
        wrapped             = 1'b0;
        if (s_data.kind == KIND_TICK && counter_enable_reg) begin
            if (prescale_count_reg < prescale_value_reg) begin
                prescale_count_next = prescale_count_reg + 32'd1;
            end else begin
                prescale_count_next = '0;
                if (step >= MATCH_W'(period_count_reg) || step[COUNT_WIDTH]) begin
                    timer_count_next = '0;
                    wrapped          = 1'b1;
                end else begin
                    timer_count_next = step[COUNT_WIDTH-1:0];
                end
            end
        end
    end

    // duration path: clamp and convert to a match value
    always_comb begin
        logic [MATCH_W-1:0] per;
        logic [MATCH_W-1:0] dur;
        per = MATCH_W'(period_count_reg);
        dur = MATCH_W'(s_data.duration);
        if (s_data.duration == '0) begin
            match_value_next = per + MATCH_W'(1);
        end else begin
            if (dur > per) begin
                dur = per;
            end
            match_value_next = per - dur;
        end
        match_idx   = MATCH_IDX_W'(s_data.channel);
        match_write = (s_data.kind == KIND_SET_DURATION)
                   && (32'(s_data.channel) < 32'(CHANNELS))
                   && (s_data.channel != period_slot_reg);
    end

    // levels after this beat, from the updated state
    always_comb begin
        logic [LEVELS_W-1:0] lv;
        logic [MATCH_W-1:0]  m;
        lv = '0;
        for (int n = 0; n < CHANNELS && n < LEVELS_W; n++) begin
            m = match_reg[n];
            if (match_write && match_idx == MATCH_IDX_W'(n)) begin
                m = match_value_next;
            end
            if (output_enable_mask_reg[n] && CH_IDX_W'(n) != period_slot_reg
                && MATCH_W'(timer_count_next) >= m) begin
                lv[n] = 1'b1;
            end
        end
        result.levels      = lv;
        result.count       = CNT_OUT_W'(timer_count_next);
        result.cycle_start = wrapped;
    end

    // configuration writes and state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_value_reg     <= '0;
            period_count_reg       <= 32'd1;
            period_slot_reg        <= '0;
            counter_enable_reg     <= 1'b0;
            output_enable_mask_reg <= '0;
            prescale_count_reg     <= '0;
            timer_count_reg        <= '0;
            for (int n = 0; n < CHANNELS; n++) begin
                match_reg[n] <= '1;
            end
        end else begin
            if (accept) begin
                prescale_count_reg <= prescale_count_next;
                timer_count_reg    <= timer_count_next;
                if (match_write) begin
                    match_reg[match_idx] <= match_value_next;
                end
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PRESCALE_VALUE: begin
                        prescale_value_reg <= cfg_wdata;
                    end
                    CFG_PERIOD_COUNT: begin
                        period_count_reg   <= cfg_wdata;
                        prescale_count_reg <= '0;
                        timer_count_reg    <= '0;
                    end
                    CFG_PERIOD_SLOT: begin
                        period_slot_reg    <= cfg_wdata[CH_IDX_W-1:0];
                        prescale_count_reg <= '0;
                        timer_count_reg    <= '0;
                    end
                    CFG_COUNTER_ENABLE: begin
                        counter_enable_reg <= cfg_wdata[0];
                    end
                    CFG_OUTPUT_ENABLE_MASK: begin
                        output_enable_mask_reg <= cfg_wdata[LEVELS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result register ahead of the buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (accept) begin
            res_valid_reg <= 1'b1;
        end else if (res_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= result;
        end
    end

    // input stalls only when the result register cannot drain
    assign s_ready = !res_valid_reg || res_ready;

    // result beat buffer
    sepwm_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid_reg),
        .in_ready  (res_ready),
        .in_data   (res_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

### src/sepwm_skid.sv
// Two-entry result buffer: output register plus skid register for the result beat.
// Depends on sepwm_pkg for the sepwm_out_t beat type.
`default_nettype none

module sepwm_skid
    import sepwm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire sepwm_out_t in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output sepwm_out_t      out_data
);

    logic       out_valid_reg, out_valid_next;
    sepwm_out_t out_data_reg, out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    sepwm_out_t skid_data_reg, skid_data_next;
    logic       push;

    // new beats are taken while the skid slot is free
    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;

    // refill the output register from skid first, else from the input
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = in_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
